FILE: rtl/todmc_pkg.sv
package todmc_pkg;

    localparam int unsigned HourW    = 5;
    localparam int unsigned MinuteW  = 6;
    localparam int unsigned SecondW  = 6;
    localparam int unsigned PhaseW   = 3;
    localparam int unsigned StepW    = 4;
    localparam int unsigned HourCntW = 8;
    localparam int unsigned TotalW   = 11;

    localparam int unsigned InDataW  = 24;
    localparam int unsigned OutDataW = 24;

    localparam logic [HourCntW-1:0] HourUnset      = 8'hFF;
    localparam logic [HourCntW-1:0] HoursPerDay    = 8'd24;
    localparam logic [PhaseW-1:0]   TicksPerStep   = 3'd6;
    localparam logic [StepW-1:0]    StepsPerMinute = 4'd10;
    localparam logic [MinuteW-1:0]  MinutesPerHour = 6'd60;

    // Command codes carried in the input tuser bit.
    typedef enum logic {
        t_cmd_tick = 1'b0,
        t_cmd_set  = 1'b1
    } t_cmd;

    typedef struct packed {
        logic [StepW-1:0]  step;
        logic [PhaseW-1:0] phase;
    } t_sec_split;

    // Splits a second value into six-second steps and the remainder. The
    // quotient uses a multiply by 43/256, which is exact for 0 to 63.
    function automatic t_sec_split split_second(input logic [SecondW-1:0] s);
        logic [13:0]        prod;
        logic [StepW-1:0]   q;
        logic [SecondW-1:0] rem;
        t_sec_split         res;
        prod      = 14'(s) * 14'd43;
        q         = prod[11:8];
        rem       = s - 6'(q) * 6'd6;
        res.step  = q;
        res.phase = rem[PhaseW-1:0];
        return res;
    endfunction

endpackage

FILE: rtl/time_of_day_minute_clock_unit.sv
// Time-of-day clock driven by one-second tick words. Each input word is either
// a tick (tuser low) or a time set (tuser high) that loads hour, minute and
// second; every input word yields exactly one output word with the current
// hour, minute and minutes since midnight, taken after that word's update.
// After reset the hour holds the not-set marker and the output shows zeros with
// its valid flag low until a set arrives; a clock that runs while not set still
// counts and wraps its hour into the valid range. The block takes one word per
// clock while the output is not stalled: an input register holds the accepted
// word, and the counter update with its constant compares then fills the output
// register. Backpressure on the output stalls both stages, and the input
// register can still take one word while a finished word waits to be taken.
module time_of_day_minute_clock_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [4:0] new_hour, [10:5] new_minute, [16:11] new_second, [23:17] zero
    input  logic [todmc_pkg::InDataW-1:0]  s_axis_tdata,
    // [0] cmd: tick or set
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [4:0] hour_now, [10:5] minute_now, [21:11] day_minutes, [23:22] zero
    output logic [todmc_pkg::OutDataW-1:0] m_axis_tdata,
    // [0] time_valid
    output logic        m_axis_tuser
);
    import todmc_pkg::*;

    // Input register stage.
    logic                  r_in_valid;
    logic                  r_in_cmd;
    logic [HourW-1:0]      r_in_hour;
    logic [MinuteW-1:0]    r_in_minute;
    logic [SecondW-1:0]    r_in_second;

    // Clock state.
    logic [PhaseW-1:0]     r_phase,  n_phase;
    logic [StepW-1:0]      r_step,   n_step;
    logic [MinuteW-1:0]    r_minute, n_minute;
    logic [HourCntW-1:0]   r_hour,   n_hour;
    logic [TotalW-1:0]     r_total,  n_total;

    // Output register stage.
    logic                  r_out_valid;
    logic                  r_out_tvalid_flag;
    logic [HourW-1:0]      r_out_hour;
    logic [MinuteW-1:0]    r_out_minute;
    logic [TotalW-1:0]     r_out_total;

    logic                  advance;
    t_sec_split            sec_split;
    logic [PhaseW-1:0]     phase_inc;
    logic [StepW-1:0]      step_inc;
    // One bit wider so that a minute loaded as 63 still sees 64 and rolls.
    logic [MinuteW:0]      minute_inc;
    logic [HourCntW-1:0]   hour_inc;
    logic [TotalW-1:0]     total_inc;
    logic [TotalW-1:0]     set_total;

    // The update stage moves whenever the output register is free or drains.
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_cmd    <= s_axis_tuser;
            r_in_hour   <= s_axis_tdata[4:0];
            r_in_minute <= s_axis_tdata[10:5];
            r_in_second <= s_axis_tdata[16:11];
        end
    end

    assign sec_split  = split_second(r_in_second);
    assign phase_inc  = r_phase + 3'd1;
    assign step_inc   = r_step + 4'd1;
    assign minute_inc = {1'b0, r_minute} + 7'd1;
    assign hour_inc   = r_hour + 8'd1;
    assign total_inc  = r_total + 11'd1;
    assign set_total  = 11'(r_in_hour) * 11'd60 + 11'(r_in_minute);

    // Cascaded counter update for a tick, or a direct load for a set.
    always_comb begin
        n_phase  = r_phase;
        n_step   = r_step;
        n_minute = r_minute;
        n_hour   = r_hour;
        n_total  = r_total;
        case (t_cmd'(r_in_cmd))
            t_cmd_set: begin
                n_hour   = 8'(r_in_hour);
                n_minute = r_in_minute;
                n_total  = set_total;
                n_step   = sec_split.step;
                n_phase  = sec_split.phase;
            end
            t_cmd_tick: begin
                n_phase = phase_inc;
                if (phase_inc >= TicksPerStep) begin
                    n_phase = '0;
                    n_step  = step_inc;
                    if (step_inc >= StepsPerMinute) begin
                        n_step   = '0;
                        n_minute = minute_inc[MinuteW-1:0];
                        n_total  = total_inc;
                        if (minute_inc >= {1'b0, MinutesPerHour}) begin
                            n_minute = '0;
                            n_hour   = hour_inc;
                            // Rolling into hour 24 starts a new day.
                            if (hour_inc == HoursPerDay) begin
                                n_hour  = '0;
                                n_total = '0;
                            end
                        end
                    end
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= '0;
            r_step   <= '0;
            r_minute <= '0;
            r_hour   <= HourUnset;
            r_total  <= '0;
        end else if (advance) begin
            r_phase  <= n_phase;
            r_step   <= n_step;
            r_minute <= n_minute;
            r_hour   <= n_hour;
            r_total  <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Fields read as zero while the hour still holds the not-set marker.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_tvalid_flag <= (n_hour != HourUnset);
            if (n_hour != HourUnset) begin
                r_out_hour   <= n_hour[HourW-1:0];
                r_out_minute <= n_minute;
                r_out_total  <= n_total;
            end else begin
                r_out_hour   <= '0;
                r_out_minute <= '0;
                r_out_total  <= '0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_tvalid_flag;
    assign m_axis_tdata  = {2'b00, r_out_total, r_out_minute, r_out_hour};

endmodule

FILE: tb/sv/time_of_day_minute_clock_unit_tb.sv
`timescale 1ns / 1ps

module time_of_day_minute_clock_unit_tb;
    import todmc_pkg::*;

    localparam int ClkHalf     = 10;
    localparam int ResetCycles = 8;
    // Ticks sent straight after reset, before any set, so that the clock runs
    // through two minutes while the hour still holds the not-set marker.
    localparam int UnsetTicks  = 130;
    localparam int RandomItems = 740;
    // Cycles with no word moving on either side before the run is declared hung.
    localparam int StallLimit  = 2000;
    // A comfortable margin past the block's input and output registers.
    localparam int DrainCycles = 8;

    // One input word as the testbench sees it.
    typedef struct packed {
        t_cmd                cmd;
        logic [HourW-1:0]    hour;
        logic [MinuteW-1:0]  minute;
        logic [SecondW-1:0]  second;
    } t_clock_cmd;

    // One output word: the time shown after the matching input word.
    typedef struct packed {
        logic                valid;
        logic [HourW-1:0]    hour;
        logic [MinuteW-1:0]  minute;
        logic [TotalW-1:0]   total;
    } t_clock_reading;

    // Receiver stall styles; each runs for a random stretch of cycles.
    typedef enum int {
        RxOpen,
        RxCoin,
        RxThird,
        RxMostly
    } t_rx_style;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [InDataW-1:0]   s_axis_tdata  = '0;
    logic                 s_axis_tuser  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OutDataW-1:0]  m_axis_tdata;
    logic                 m_axis_tuser;

    // Words waiting to be sent, and readings the block still owes us.
    t_clock_cmd     pending_cmds[$];
    t_clock_reading expected_readings[$];

    // Our own copy of the clock state, starting from its reset values.
    logic [PhaseW-1:0]   sec_phase  = '0;
    logic [StepW-1:0]    six_sec    = '0;
    logic [MinuteW-1:0]  minute_cnt = '0;
    logic [HourCntW-1:0] hour_cnt   = HourUnset;
    logic [TotalW-1:0]   day_total  = '0;

    int mismatches  = 0;
    int idle_cycles = 0;

    always #(ClkHalf) i_clk = ~i_clk;

    time_of_day_minute_clock_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Applies one accepted word to the clock copy and queues the reading the
    // block must show afterwards. A set loads the fields as given, so hours of
    // 24 to 31, minutes of 60 and up and seconds of 60 and up all land here; the
    // minutes and seconds only roll over on the following counting steps.
    task automatic advance_clock(input t_clock_cmd c);
        int ph;
        int st;
        int mn;
        int hr;
        int tot;
        t_clock_reading r;
        if (c.cmd == t_cmd_set) begin
            hr  = int'(c.hour);
            mn  = int'(c.minute);
            tot = (hr * int'(MinutesPerHour) + mn) % (1 << TotalW);
            st  = int'(c.second) / int'(TicksPerStep);
            ph  = int'(c.second) % int'(TicksPerStep);
        end else begin
            ph  = int'(sec_phase) + 1;
            st  = int'(six_sec);
            mn  = int'(minute_cnt);
            hr  = int'(hour_cnt);
            tot = int'(day_total);
            if (ph >= int'(TicksPerStep)) begin
                ph = 0;
                st = st + 1;
                if (st >= int'(StepsPerMinute)) begin
                    st  = 0;
                    mn  = mn + 1;
                    tot = (tot + 1) % (1 << TotalW);
                    if (mn >= int'(MinutesPerHour)) begin
                        // The hour counts through the not-set marker and wraps;
                        // only an exact 24 starts a new day.
                        mn = 0;
                        hr = (hr + 1) % (1 << HourCntW);
                        if (hr == int'(HoursPerDay)) begin
                            hr  = 0;
                            tot = 0;
                        end
                    end
                end
            end
        end
        sec_phase  = PhaseW'(ph);
        six_sec    = StepW'(st);
        minute_cnt = MinuteW'(mn);
        hour_cnt   = HourCntW'(hr);
        day_total  = TotalW'(tot);
        if (hour_cnt != HourUnset) begin
            r = '{1'b1, hour_cnt[HourW-1:0], minute_cnt, day_total};
        end else begin
            r = '0;
        end
        expected_readings.push_back(r);
    endtask

    task automatic queue_ticks(input int n);
        // The time fields of a tick are don't-care, so they carry noise.
        repeat (n) begin
            pending_cmds.push_back('{t_cmd_tick, HourW'($urandom), MinuteW'($urandom),
                                     SecondW'($urandom)});
        end
    endtask

    task automatic queue_set(input logic [HourW-1:0] h, input logic [MinuteW-1:0] m,
                             input logic [SecondW-1:0] s);
        pending_cmds.push_back('{t_cmd_set, h, m, s});
    endtask

    // Sender: bursts of random length separated by random gaps, with the odd
    // long burst that runs back to back. A word stays on the bus until taken.
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        t_clock_cmd c;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                c = pending_cmds.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {{(InDataW - HourW - MinuteW - SecondW){1'b0}},
                                  c.second, c.minute, c.hour};
                s_axis_tuser  <= c.cmd;
                burst_left--;
                if (burst_left <= 0) begin
                    if ($urandom_range(0, 7) == 0) begin
                        burst_left = $urandom_range(40, 120);
                        gap_left   = 0;
                    end else begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = $urandom_range(0, 6);
                    end
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: switches between stall styles so that backpressure hits the
    // pipeline in every phase, including stretches where it never stalls.
    t_rx_style rx_style    = RxOpen;
    int        style_left  = 0;
    int        third_phase = 0;

    always @(posedge i_clk) begin
        if (style_left == 0) begin
            rx_style   = t_rx_style'($urandom_range(0, 3));
            style_left = $urandom_range(32, 128);
        end else begin
            style_left--;
        end
        third_phase = (third_phase + 1) % 3;
        case (rx_style)
            RxOpen: begin
                m_axis_tready <= 1'b1;
            end
            RxCoin: begin
                m_axis_tready <= 1'($urandom_range(0, 1));
            end
            RxThird: begin
                m_axis_tready <= (third_phase == 0);
            end
            default: begin
                m_axis_tready <= ($urandom_range(0, 4) != 0);
            end
        endcase
    end

    // Monitor: checks an output word against the oldest reading owed, then
    // feeds an input word taken at the same edge to the clock copy. Both sides
    // are read from bus signals, which only change by nonblocking assignment.
    always @(posedge i_clk) begin
        t_clock_reading want;
        t_clock_reading got;
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{m_axis_tuser, m_axis_tdata[4:0], m_axis_tdata[10:5],
                        m_axis_tdata[21:11]};
                if (expected_readings.size() == 0) begin
                    report_mismatch($sformatf("unexpected output word %h", m_axis_tdata));
                end else begin
                    want = expected_readings.pop_front();
                    if (got.valid !== want.valid)
                        report_mismatch($sformatf("time_valid %b, want %b",
                                                  got.valid, want.valid));
                    if (got.hour !== want.hour)
                        report_mismatch($sformatf("hour_now %0d, want %0d",
                                                  got.hour, want.hour));
                    if (got.minute !== want.minute)
                        report_mismatch($sformatf("minute_now %0d, want %0d",
                                                  got.minute, want.minute));
                    if (got.total !== want.total)
                        report_mismatch($sformatf("day_minutes %0d, want %0d",
                                                  got.total, want.total));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                advance_clock('{t_cmd'(s_axis_tuser), s_axis_tdata[4:0],
                                s_axis_tdata[10:5], s_axis_tdata[16:11]});
            end
        end
    end

    initial begin
        logic [HourW-1:0]   h;
        logic [MinuteW-1:0] m;
        logic [SecondW-1:0] s;
        int                 first_random;

        // Running from reset with no time set: minutes advance internally
        // while every reading stays at zero with the valid flag low.
        queue_ticks(UnsetTicks);

        // Directed words: field extremes and the rollover corner cases.
        queue_set(5'd0, 6'd0, 6'd0);
        queue_ticks(1);
        // End of day: 23:59:59 plus one second restarts at midnight.
        queue_set(5'd23, 6'd59, 6'd59);
        queue_ticks(1);
        // All fields at their maximum: the loaded step count and minute are
        // already past their limits and both roll over on the third tick.
        queue_set(5'd31, 6'd63, 6'd63);
        queue_ticks(3);
        // An hour loaded as 24 is not a day boundary; it counts on to 25 and
        // the minutes total passes 1439.
        queue_set(5'd24, 6'd59, 6'd59);
        queue_ticks(1);
        queue_set(5'd22, 6'd59, 6'd59);
        queue_ticks(1);
        queue_set(5'd0, 6'd63, 6'd0);
        // A second of 60 loads a full step count that rolls at the next step.
        queue_set(5'd31, 6'd0, 6'd60);
        queue_ticks(6);
        // Alternating bit patterns across every field.
        queue_set(5'd21, 6'd42, 6'd21);
        queue_set(5'd10, 6'd21, 6'd42);

        // Random part: mostly a set near a boundary followed by a run of ticks,
        // with the odd stray set of arbitrary field values.
        first_random = pending_cmds.size();
        while (pending_cmds.size() - first_random < RandomItems) begin
            if ($urandom_range(0, 9) == 0) begin
                queue_set(HourW'($urandom), MinuteW'($urandom), SecondW'($urandom));
            end else begin
                case ($urandom_range(0, 19))
                    0, 1, 2:    h = 5'd23;
                    3, 4, 5, 6: h = HourW'($urandom_range(24, 31));
                    default:    h = HourW'($urandom_range(0, 23));
                endcase
                m = ($urandom_range(0, 1) == 0) ? MinuteW'($urandom_range(55, 63))
                                                : MinuteW'($urandom);
                s = ($urandom_range(0, 4) < 3) ? SecondW'($urandom_range(48, 63))
                                               : SecondW'($urandom);
                queue_set(h, m, s);
                queue_ticks(($urandom_range(0, 5) == 0) ? $urandom_range(40, 130)
                                                        : $urandom_range(1, 20));
            end
        end

        repeat (ResetCycles) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every word to be sent and every reading to come back.
        do begin
            @(negedge i_clk);
        end while ((pending_cmds.size() > 0 || s_axis_tvalid || expected_readings.size() > 0)
                   && idle_cycles < StallLimit);

        if (idle_cycles >= StallLimit) begin
            report_mismatch($sformatf("no word moved for %0d cycles", StallLimit));
        end else begin
            // Any stray output after the last reading is caught by the monitor.
            repeat (DrainCycles) @(negedge i_clk);
        end
        if (expected_readings.size() > 0)
            report_mismatch($sformatf("%0d readings never arrived", expected_readings.size()));

        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
